// File: src/pressure_temp_compensation_macros.svh
// assertion macros shared by the compensation block
`ifndef PRESSURE_TEMP_COMPENSATION_MACROS_SVH
`define PRESSURE_TEMP_COMPENSATION_MACROS_SVH

// condition must never hold at a clock edge out of reset
`define PTC_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define PTC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// File: src/ptc_pkg.sv
package ptc_pkg;

	// configuration register indexes
	localparam logic [7:0] RegTempCalib     = 8'd0;
	localparam logic [7:0] RegPressCalibLo  = 8'd1;
	localparam logic [7:0] RegPressCalibHi  = 8'd2;
	localparam logic [7:0] RegPressCalibP9  = 8'd3;

	// queue between front and back
	localparam int QDepth = 4;
	localparam int QAw    = $clog2(QDepth);

	// divider stages, one quotient bit each
	localparam int DivSteps = 32;

	// calibration words, widened to 32 bits
	typedef struct packed {
		logic [31:0] t1;
		logic [31:0] t2;
		logic [31:0] t3;
		logic [31:0] p1;
		logic [31:0] p2;
		logic [31:0] p3;
		logic [31:0] p4;
		logic [31:0] p5;
		logic [31:0] p6;
		logic [31:0] p7;
		logic [31:0] p8;
		logic [31:0] p9;
	} calib_t;

	// one request as passed from front to back
	typedef struct packed {
		logic [31:0] temp;
		logic [31:0] divisor;
		logic [31:0] numer;
	} entry_t;

	function automatic logic [31:0] sext16(input logic [15:0] v);
		sext16 = {{16{v[15]}}, v};
	endfunction

	function automatic logic [31:0] zext16(input logic [15:0] v);
		zext16 = {16'd0, v};
	endfunction

	// arithmetic right shift of a 32-bit word, kept apart from the
	// surrounding expression so the sign always fills
	function automatic logic [31:0] asr32(input logic [31:0] x, input logic [4:0] n);
		asr32 = $signed(x) >>> n;
	endfunction

endpackage

// File: src/pressure_temp_compensation.sv
// channel  | handshake               | payload
// ---------+-------------------------+----------------------------------------------
// req      | req_valid / req_stall   | raw_pressure, raw_temperature
// res      | res_valid / res_stall   | temperature_centi, pressure_pa, pressure_valid
// cfg      | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// one request per cycle sustained while req_stall is low; a result shows once its request
// has passed the front stages, the queue, 1 divider entry, 32 divide and 3 correction stages
// a four-entry queue parts front and back, each stalls on its own enable
// arst_n clears all valid bits, queue pointers and calibration registers
// cfg_ready is always high; writes to indexes above three are dropped
`include "pressure_temp_compensation_macros.svh"

module pressure_temp_compensation (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [19:0] raw_pressure,
	input  logic [19:0] raw_temperature,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [31:0] temperature_centi,
	output logic [31:0] pressure_pa,
	output logic        pressure_valid
);

	logic [47:0] temp_calib_q;
	logic [63:0] press_lo_q, press_hi_q;
	logic [15:0] p9_q;

	ptc_pkg::calib_t cal;
	ptc_pkg::entry_t push_data, head;
	logic q_full, q_empty, q_push, q_pop;

	assign cfg_ready = 1'b1;

	// calibration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_calib_q <= '0;
			press_lo_q   <= '0;
			press_hi_q   <= '0;
			p9_q         <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				ptc_pkg::RegTempCalib:    temp_calib_q <= cfg_data[47:0];
				ptc_pkg::RegPressCalibLo: press_lo_q   <= cfg_data;
				ptc_pkg::RegPressCalibHi: press_hi_q   <= cfg_data;
				ptc_pkg::RegPressCalibP9: p9_q         <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// widened calibration words
	always_comb begin
		cal.t1 = ptc_pkg::zext16(temp_calib_q[15:0]);
		cal.t2 = ptc_pkg::sext16(temp_calib_q[31:16]);
		cal.t3 = ptc_pkg::sext16(temp_calib_q[47:32]);
		cal.p1 = ptc_pkg::zext16(press_lo_q[15:0]);
		cal.p2 = ptc_pkg::sext16(press_lo_q[31:16]);
		cal.p3 = ptc_pkg::sext16(press_lo_q[47:32]);
		cal.p4 = ptc_pkg::sext16(press_lo_q[63:48]);
		cal.p5 = ptc_pkg::sext16(press_hi_q[15:0]);
		cal.p6 = ptc_pkg::sext16(press_hi_q[31:16]);
		cal.p7 = ptc_pkg::sext16(press_hi_q[47:32]);
		cal.p8 = ptc_pkg::sext16(press_hi_q[63:48]);
		cal.p9 = ptc_pkg::sext16(p9_q);
	end

	ptc_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.cal             (cal),
		.req_valid       (req_valid),
		.req_stall       (req_stall),
		.raw_pressure    (raw_pressure),
		.raw_temperature (raw_temperature),
		.q_full          (q_full),
		.push            (q_push),
		.push_data       (push_data)
	);

	ptc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (push_data),
		.pop       (q_pop),
		.head      (head),
		.full      (q_full),
		.empty     (q_empty)
	);

	ptc_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.cal               (cal),
		.q_empty           (q_empty),
		.head              (head),
		.pop               (q_pop),
		.res_valid         (res_valid),
		.res_stall         (res_stall),
		.temperature_centi (temperature_centi),
		.pressure_pa       (pressure_pa),
		.pressure_valid    (pressure_valid)
	);

	// queue never overrun or underrun, zero divisor gives zero pressure
	`PTC_ASSERT_NEVER(a_no_overrun, clk, arst_n, q_push && q_full, "queue push while full")
	`PTC_ASSERT_NEVER(a_no_underrun, clk, arst_n, q_pop && q_empty, "queue pop while empty")
	`PTC_ASSERT_IMPLY(a_zero_press, clk, arst_n, res_valid && !pressure_valid, pressure_pa == '0, "bad pa")

endmodule

// File: src/ptc_front.sv
module ptc_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ptc_pkg::calib_t      cal,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  logic [19:0]          raw_pressure,
	input  logic [19:0]          raw_temperature,
	input  logic                 q_full,
	output logic                 push,
	output ptc_pkg::entry_t      push_data
);

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;

	logic [31:0] m1_s1, m2_s1;
	logic [19:0] adc_p_s1, adc_p_s2, adc_p_s3, adc_p_s4, adc_p_s5, adc_p_s6;
	logic [31:0] x1_s2, m3_s2;
	logic [31:0] tfine_s3;
	logic [31:0] t5_s4, qq_s4, ap5_s4, p2a_s4;
	logic [31:0] temp_s5, b_s5, p3m_s5, ap5_s5, p2a_s5;
	logic [31:0] temp_s6, b_s6, a1_s6;
	logic [31:0] temp_s7, am_s7, pn_s7;
	logic [31:0] temp_s8, div_s8, numer_s8;

	logic [31:0] dx, dd, x2, a0, q, bsum, bfin, a1;

	// whole pipe advances unless the queue cannot take its last stage
	assign en        = !(v_s8 && q_full);
	assign req_stall = !en;
	assign push      = v_s8 && !q_full;
	assign push_data = '{temp: temp_s8, divisor: div_s8, numer: numer_s8};

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8} <= '0;
		end else if (en) begin
			v_s1 <= req_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	// combinational pieces between stages
	always_comb begin
		dx   = {15'd0, raw_temperature[19:3]} - {cal.t1[30:0], 1'b0};
		dd   = {16'd0, raw_temperature[19:4]} - cal.t1;
		x2   = $signed(m3_s2) >>> 14;
		a0   = ptc_pkg::asr32(tfine_s3, 5'd1) - 32'd64000;
		q    = $signed(a0) >>> 2;
		bsum = b_s5 + {ap5_s5[30:0], 1'b0};
		bfin = ptc_pkg::asr32(bsum, 5'd2) + {cal.p4[15:0], 16'd0};
		a1   = $signed(($signed(p3m_s5) >>> 3) + ($signed(p2a_s5) >>> 1)) >>> 18;
	end

	// payload stages
	always_ff @(posedge clk) begin
		if (en) begin
			// raw readings into first products
			m1_s1    <= dx * cal.t2;
			m2_s1    <= dd * dd;
			adc_p_s1 <= raw_pressure;
			// temperature terms
			x1_s2    <= $signed(m1_s1) >>> 11;
			m3_s2    <= ptc_pkg::asr32(m2_s1, 5'd12) * cal.t3;
			adc_p_s2 <= adc_p_s1;
			// fine temperature
			tfine_s3 <= x1_s2 + x2;
			adc_p_s3 <= adc_p_s2;
			// pressure first products
			t5_s4    <= tfine_s3 * 32'd5;
			qq_s4    <= q * q;
			ap5_s4   <= a0 * cal.p5;
			p2a_s4   <= cal.p2 * a0;
			adc_p_s4 <= adc_p_s3;
			// second products
			temp_s5  <= $signed(t5_s4 + 32'd128) >>> 8;
			b_s5     <= ptc_pkg::asr32(qq_s4, 5'd11) * cal.p6;
			p3m_s5   <= cal.p3 * ptc_pkg::asr32(qq_s4, 5'd13);
			ap5_s5   <= ap5_s4;
			p2a_s5   <= p2a_s4;
			adc_p_s5 <= adc_p_s4;
			// offset and scale terms
			temp_s6  <= temp_s5;
			b_s6     <= bfin;
			a1_s6    <= a1;
			adc_p_s6 <= adc_p_s5;
			// divisor product and numerator base
			temp_s7  <= temp_s6;
			am_s7    <= (32'd32768 + a1_s6) * cal.p1;
			pn_s7    <= 32'd1048576 - {12'd0, adc_p_s6} - ptc_pkg::asr32(b_s6, 5'd12);
			// divisor and numerator
			temp_s8  <= temp_s7;
			div_s8   <= $signed(am_s7) >>> 15;
			numer_s8 <= pn_s7 * 32'd3125;
		end
	end

endmodule

// File: src/ptc_queue.sv
module ptc_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  ptc_pkg::entry_t  push_data,
	input  logic             pop,
	output ptc_pkg::entry_t  head,
	output logic             full,
	output logic             empty
);

	ptc_pkg::entry_t           mem_q [ptc_pkg::QDepth];
	logic [ptc_pkg::QAw-1:0]   wp_q, rp_q;
	logic [ptc_pkg::QAw:0]     cnt_q;

	assign full  = (cnt_q == (ptc_pkg::QAw+1)'(ptc_pkg::QDepth));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rp_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop)  rp_q <= rp_q + 1'b1;
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_data;
	end

endmodule

// File: src/ptc_back.sv
module ptc_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ptc_pkg::calib_t      cal,
	input  logic                 q_empty,
	input  ptc_pkg::entry_t      head,
	output logic                 pop,
	output logic                 res_valid,
	input  logic                 res_stall,
	output logic [31:0]          temperature_centi,
	output logic [31:0]          pressure_pa,
	output logic                 pressure_valid
);

	localparam int N = ptc_pkg::DivSteps;

	logic        en;
	logic        v_s   [N+1];
	logic [31:0] rem_s [N+1];
	logic [31:0] nq_s  [N+1];
	logic [31:0] den_s [N+1];
	logic        dbl_s [N+1];
	logic [31:0] tmp_s [N+1];

	logic        v_p1, v_p2, v_p3;
	logic [31:0] p_p1, m_p1, em_p1, tmp_p1;
	logic [31:0] p_p2, cm_p2, e_p2, tmp_p2;
	logic [31:0] p_p3, tmp_p3;
	logic        nz_p1, nz_p2, nz_p3;

	logic [31:0] quo, csum;

	// single enable for the whole back pipe
	assign en  = !(v_p3 && res_stall);
	assign pop = en && !q_empty;

	// entry stage: pick double-then-divide or divide-then-double
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= pop;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= '0;
			den_s[0] <= head.divisor;
			tmp_s[0] <= head.temp;
			dbl_s[0] <= head.numer[31];
			nq_s[0]  <= head.numer[31] ? head.numer : {head.numer[30:0], 1'b0};
		end
	end

	// restoring divider, one quotient bit per stage
	for (genvar k = 0; k < N; k++) begin : g_div
		logic [32:0] trial, diff;

		always_comb begin
			trial = {rem_s[k], nq_s[k][31]};
			diff  = trial - {1'b0, den_s[k]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= diff[32] ? trial[31:0] : diff[31:0];
				nq_s[k+1]  <= {nq_s[k][30:0], !diff[32]};
				den_s[k+1] <= den_s[k];
				dbl_s[k+1] <= dbl_s[k];
				tmp_s[k+1] <= tmp_s[k];
			end
		end
	end

	// correction terms after the divide
	always_comb begin
		quo  = dbl_s[N] ? {nq_s[N][30:0], 1'b0} : nq_s[N];
		csum = ptc_pkg::asr32(cm_p2, 5'd12) + e_p2 + cal.p7;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_p1, v_p2, v_p3} <= '0;
		end else if (en) begin
			v_p1 <= v_s[N];
			v_p2 <= v_p1;
			v_p3 <= v_p2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// squared and linear products
			p_p1   <= quo;
			m_p1   <= {3'd0, quo[31:3]} * {3'd0, quo[31:3]};
			em_p1  <= {2'd0, quo[31:2]} * cal.p8;
			nz_p1  <= (den_s[N] != '0);
			tmp_p1 <= tmp_s[N];
			// scaled by P9
			p_p2   <= p_p1;
			cm_p2  <= cal.p9 * {13'd0, m_p1[31:13]};
			e_p2   <= $signed(em_p1) >>> 13;
			nz_p2  <= nz_p1;
			tmp_p2 <= tmp_p1;
			// final pressure
			p_p3   <= nz_p2 ? (p_p2 + ptc_pkg::asr32(csum, 5'd4)) : '0;
			nz_p3  <= nz_p2;
			tmp_p3 <= tmp_p2;
		end
	end

	assign res_valid         = v_p3;
	assign temperature_centi = tmp_p3;
	assign pressure_pa       = p_p3;
	assign pressure_valid    = nz_p3;

endmodule
